@@ rtl/xrc_pkg.sv @@
package xrc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PendW   = 24;
  localparam int unsigned RotAmt  = 3;
  localparam logic [WordW-1:0] SealConst = 32'h03F1_379E;

  typedef enum logic [1:0] {
    REQ_DATA   = 2'd0,
    REQ_SEAL   = 2'd1,
    REQ_FINISH = 2'd2
  } req_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [ByteW-1:0] data_byte;
    logic             end_of_file;
  } xrc_item_t;

  typedef struct packed {
    logic [WordW-1:0] checksum;
    logic             open_file_error;
  } xrc_result_t;

  function automatic logic [WordW-1:0] rotl3(input logic [WordW-1:0] x);
    rotl3 = {x[WordW-RotAmt-1:0], x[WordW-1:WordW-RotAmt]};
  endfunction

endpackage

@@ rtl/multi_file_xor_rotate_checksum.sv @@
// multi-file xor-rotate checksum
// input channel: in_valid/in_ready with one word per request; in_req_type
//   selects a data byte (in_data_byte, in_end_of_file marks the last byte
//   of a file), a seal, or a finish that emits the checksum
// result channel: out_valid/out_ready with out_checksum and
//   out_open_file_error; only a finish produces a result word
// result path: a finish passes the input register, then the state is read
//   into the result register
// throughput: one input word per cycle while no finish waits on a
//   held result; the state update is one rotate-xor chain of at most
//   four steps between the input register and the state registers
// reset: all file and running state returns to zero, both channels empty
// stall: a held result blocks only the next finish; data bytes and seals
//   keep flowing; once the input register holds a finish behind a held
//   result, in_ready drops until out_ready frees the result register
module multi_file_xor_rotate_checksum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_checksum,
  output logic        out_open_file_error
);
  import xrc_pkg::*;

  logic        take;
  logic        item_valid;
  xrc_item_t   item;
  logic        out_room;
  logic        res_valid;
  xrc_result_t res;

  xrc_in_reg u_in_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_data_byte   (in_data_byte),
    .in_end_of_file (in_end_of_file),
    .take_i         (take),
    .item_valid_o   (item_valid),
    .item_o         (item)
  );

  xrc_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_room_i   (out_room),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  xrc_out_reg u_out_reg (
    .clk                 (clk),
    .rst_n               (rst_n),
    .res_valid_i         (res_valid),
    .res_i               (res),
    .out_room_o          (out_room),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_checksum        (out_checksum),
    .out_open_file_error (out_open_file_error)
  );

endmodule

@@ rtl/xrc_in_reg.sv @@
module xrc_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_file,
  input  logic              take_i,
  output logic              item_valid_o,
  output xrc_pkg::xrc_item_t item_o
);
  import xrc_pkg::*;

  logic      valid_r;
  xrc_item_t item_r;

  assign in_ready     = !valid_r || take_i;
  assign item_valid_o = valid_r;
  assign item_o       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.req_type    <= in_req_type;
      item_r.data_byte   <= in_data_byte;
      item_r.end_of_file <= in_end_of_file;
    end
  end

endmodule

@@ rtl/xrc_core.sv @@
module xrc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid_i,
  input  xrc_pkg::xrc_item_t  item_i,
  input  logic                out_room_i,
  output logic                take_o,
  output logic                res_valid_o,
  output xrc_pkg::xrc_result_t res_o
);
  import xrc_pkg::*;

  logic [WordW-1:0] v_r, v_nxt;
  logic             sealed_r, sealed_nxt;
  logic [WordW-1:0] hash_r, hash_nxt;
  logic [PendW-1:0] pbytes_r, pbytes_nxt;
  logic [1:0]       pcnt_r, pcnt_nxt;
  logic             open_r, open_nxt;
  logic             err_r, err_nxt;

  logic [WordW-1:0] hash_eff;
  logic [PendW-1:0] pbytes_eff;
  logic [1:0]       pcnt_eff;
  logic [WordW-1:0] fold;
  logic [WordW-1:0] fhash;
  logic             is_finish;

  // an idle file always holds zeros, gating keeps that explicit
  assign hash_eff   = open_r ? hash_r : '0;
  assign pbytes_eff = open_r ? pbytes_r : '0;
  assign pcnt_eff   = open_r ? pcnt_r : 2'd0;

  assign is_finish   = (item_i.req_type == REQ_FINISH);
  assign take_o      = item_valid_i && (!is_finish || out_room_i);
  assign res_valid_o = item_valid_i && is_finish && out_room_i;
  assign res_o.checksum        = v_r;
  assign res_o.open_file_error = err_r || open_r;

  // tail fold of up to two held bytes and the last byte
  always_comb begin
    fold = hash_eff;
    for (int k = 0; k < 2; k++) begin
      if (2'(k) < pcnt_eff) begin
        fold = rotl3(fold ^ {{(WordW-ByteW){1'b0}}, pbytes_eff[8*k +: 8]});
      end
    end
    fold = rotl3(fold ^ {{(WordW-ByteW){1'b0}}, item_i.data_byte});
  end

  always_comb begin
    v_nxt      = v_r;
    sealed_nxt = sealed_r;
    hash_nxt   = hash_r;
    pbytes_nxt = pbytes_r;
    pcnt_nxt   = pcnt_r;
    open_nxt   = open_r;
    err_nxt    = err_r;
    fhash      = hash_eff;
    if (take_o) begin
      case (item_i.req_type)
        REQ_DATA: begin
          pbytes_nxt = pbytes_eff;
          pcnt_nxt   = pcnt_eff;
          open_nxt   = 1'b1;
          if (pcnt_eff == 2'd3) begin
            fhash      = rotl3(hash_eff ^ {item_i.data_byte, pbytes_eff});
            pbytes_nxt = '0;
            pcnt_nxt   = 2'd0;
          end else if (item_i.end_of_file) begin
            fhash = fold;
          end else begin
            case (pcnt_eff)
              2'd0:    pbytes_nxt[7:0]   = item_i.data_byte;
              2'd1:    pbytes_nxt[15:8]  = item_i.data_byte;
              default: pbytes_nxt[23:16] = item_i.data_byte;
            endcase
            pcnt_nxt = pcnt_eff + 2'd1;
          end
          hash_nxt = fhash;
          if (item_i.end_of_file) begin
            v_nxt      = sealed_r ? rotl3(v_r ^ fhash) : (v_r ^ fhash);
            hash_nxt   = '0;
            pbytes_nxt = '0;
            pcnt_nxt   = 2'd0;
            open_nxt   = 1'b0;
          end
        end
        REQ_SEAL: begin
          if (open_r) begin
            err_nxt = 1'b1;
          end
          hash_nxt   = '0;
          pbytes_nxt = '0;
          pcnt_nxt   = 2'd0;
          open_nxt   = 1'b0;
          v_nxt      = rotl3(rotl3(v_r) ^ SealConst);
          sealed_nxt = 1'b1;
        end
        REQ_FINISH: begin
          v_nxt      = '0;
          sealed_nxt = 1'b0;
          hash_nxt   = '0;
          pbytes_nxt = '0;
          pcnt_nxt   = 2'd0;
          open_nxt   = 1'b0;
          err_nxt    = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      sealed_r <= 1'b0;
      hash_r   <= '0;
      pbytes_r <= '0;
      pcnt_r   <= 2'd0;
      open_r   <= 1'b0;
      err_r    <= 1'b0;
    end else begin
      v_r      <= v_nxt;
      sealed_r <= sealed_nxt;
      hash_r   <= hash_nxt;
      pbytes_r <= pbytes_nxt;
      pcnt_r   <= pcnt_nxt;
      open_r   <= open_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

@@ rtl/xrc_out_reg.sv @@
module xrc_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid_i,
  input  xrc_pkg::xrc_result_t res_i,
  output logic                 out_room_o,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_checksum,
  output logic                 out_open_file_error
);
  import xrc_pkg::*;

  logic        valid_r;
  xrc_result_t res_r;

  assign out_room_o          = !valid_r || out_ready;
  assign out_valid           = valid_r;
  assign out_checksum        = res_r.checksum;
  assign out_open_file_error = res_r.open_file_error;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_room_o) begin
      valid_r <= res_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid_i && out_room_o) begin
      res_r <= res_i;
    end
  end

endmodule
